[sv/char_lcd_frame_refresh_defines.svh]
// ----------------------------------------------------------------------------
// Character LCD refresh scanner - assertion macros
// Shared property wrappers for the modules of the scanner.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_FRAME_REFRESH_DEFINES_SVH
`define CHAR_LCD_FRAME_REFRESH_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CLFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define CLFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/clfr_pkg.sv]
// ----------------------------------------------------------------------------
// clfr_pkg
// Types, codes and helpers shared by the LCD refresh scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clfr_pkg;

	localparam int FRAME_CELLS_DEF = 80;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] SET_ADDR_CMD = 8'h80;

	// input modes
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_TICK    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// queued operation kinds
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// register indexes
	localparam logic [2:0] REG_ROW_COUNT    = 3'd0;
	localparam logic [2:0] REG_COLUMN_COUNT = 3'd1;
	localparam logic [2:0] REG_ROW_OFFSET_0 = 3'd2;
	localparam logic [2:0] REG_ROW_OFFSET_1 = 3'd3;
	localparam logic [2:0] REG_ROW_OFFSET_2 = 3'd4;
	localparam logic [2:0] REG_ROW_OFFSET_3 = 3'd5;

	typedef struct packed {
		logic [2:0]      row_count;
		logic [4:0]      column_count;
		logic [3:0][6:0] row_offset;
	} cfg_t;

	// one queued operation; wdata is the character for a write and the
	// set-address byte for a restart
	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] addr;
		logic [7:0] wdata;
		logic       wrap;
		logic [7:0] cmd;
	} op_t;

	function automatic logic geom_ok(input logic [2:0] rows, input logic [4:0] cols);
		logic ok;
		ok = 1'b0;
		if (rows == 3'd2)
			ok = (cols == 5'd16) || (cols == 5'd20);
		else if (rows == 3'd4)
			ok = (cols == 5'd20);
		return ok;
	endfunction

endpackage

`default_nettype wire

[sv/clfr_ram.sv]
// ----------------------------------------------------------------------------
// clfr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/clfr_front.sv]
// ----------------------------------------------------------------------------
// clfr_front
// Accepts requests, tracks the scan position and queues operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clfr_front #(
	parameter int FRAME_CELLS = clfr_pkg::FRAME_CELLS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire clfr_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       mode,
	input  wire logic [6:0]       cell_index,
	input  wire logic [7:0]       cell_char,
	input  wire logic             q_full,
	output logic                  push,
	output clfr_pkg::op_t         op
);
	import clfr_pkg::*;

	localparam logic [6:0] CELLS_LIM = 7'(FRAME_CELLS);

	logic [1:0] row_q;
	logic [4:0] col_q;
	logic       accept;
	logic       geo_ok;
	logic       push_en;
	logic [5:0] next_col;
	logic       col_wrap;
	logic [2:0] row_inc;
	logic [1:0] new_row;
	logic [6:0] tick_addr;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign geo_ok   = geom_ok(cfg.row_count, cfg.column_count);
	assign next_col = {1'b0, col_q} + 6'd1;
	assign col_wrap = next_col >= {1'b0, cfg.column_count};
	assign row_inc  = {1'b0, row_q} + 3'd1;
	assign new_row  = (row_inc >= cfg.row_count) ? 2'd0 : row_inc[1:0];
	// row <= 3 and columns <= 31, so the cell number stays below 128
	assign tick_addr = 7'({5'd0, row_q} * {2'd0, cfg.column_count}) + {2'd0, col_q};
	assign push     = accept && push_en;

	always_comb begin
		push_en  = 1'b0;
		op.kind  = OP_WRITE;
		op.addr  = cell_index;
		op.wdata = cell_char;
		op.wrap  = 1'b0;
		op.cmd   = SET_ADDR_CMD | {1'b0, cfg.row_offset[new_row]};
		unique case (mode)
			MODE_WRITE: begin
				push_en = cell_index < CELLS_LIM;
			end
			MODE_TICK: begin
				push_en = geo_ok;
				op.kind = OP_TICK;
				op.addr = tick_addr;
				op.wrap = col_wrap;
			end
			MODE_RESTART: begin
				push_en  = geo_ok;
				op.kind  = OP_RESTART;
				op.wdata = SET_ADDR_CMD | {1'b0, cfg.row_offset[0]};
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
			col_q <= 5'd0;
		end else if (accept) begin
			if (mode == MODE_RESTART) begin
				row_q <= 2'd0;
				col_q <= 5'd0;
			end else if (mode == MODE_TICK && geo_ok) begin
				if (col_wrap) begin
					row_q <= new_row;
					col_q <= 5'd0;
				end else begin
					col_q <= next_col[4:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/clfr_fifo.sv]
// ----------------------------------------------------------------------------
// clfr_fifo
// Short register queue of operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_frame_refresh_defines.svh"

module clfr_fifo #(
	parameter int DEPTH = clfr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clfr_pkg::op_t  push_op,
	input  wire logic           pop,
	output clfr_pkg::op_t       head,
	output logic                full,
	output logic                empty
);
	import clfr_pkg::*;

	// DEPTH must be a power of two so the pointers wrap naturally; the module does not check it
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	op_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign full  = count_q == (PW+1)'(DEPTH);
	assign empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`CLFR_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`CLFR_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

[sv/clfr_back.sv]
// ----------------------------------------------------------------------------
// clfr_back
// Executes queued operations against the frame store; drives the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_frame_refresh_defines.svh"

module clfr_back #(
	parameter int FRAME_CELLS = clfr_pkg::FRAME_CELLS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire clfr_pkg::op_t  head,
	input  wire logic           q_empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          lcd_byte,
	output logic                is_data,
	output logic                last
);
	import clfr_pkg::*;

	localparam int AW = $clog2(FRAME_CELLS);
	localparam logic [6:0] CELLS_LIM = 7'(FRAME_CELLS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CMD  = 2'd2;

	logic [1:0]             state_q;
	logic [FRAME_CELLS-1:0] vbit_q;
	logic                   out_valid_q;
	logic [7:0]             lcd_byte_q;
	logic                   is_data_q;
	logic                   last_q;
	logic                   hit_q;
	logic                   wrap_q;
	logic [7:0]             cmd_q;
	logic                   out_free;
	logic [AW-1:0]          cell_addr;
	logic                   in_range;
	logic                   ram_we;
	logic                   ram_re;
	logic [7:0]             ram_rdata;
	logic                   load_rst;
	logic                   load_data;
	logic                   load_cmd;

	assign out_free  = !out_valid_q || !out_stall;
	assign cell_addr = head.addr[AW-1:0];
	assign in_range  = head.addr < CELLS_LIM;
	assign pop       = (state_q == S_IDLE) && !q_empty
	                   && (head.kind != OP_RESTART || out_free);
	assign ram_we    = pop && head.kind == OP_WRITE;
	assign ram_re    = pop && head.kind == OP_TICK;
	assign load_rst  = pop && head.kind == OP_RESTART;
	assign load_data = (state_q == S_READ) && out_free;
	assign load_cmd  = (state_q == S_CMD) && out_free;

	assign out_valid = out_valid_q;
	assign lcd_byte  = lcd_byte_q;
	assign is_data   = is_data_q;
	assign last      = last_q;

	clfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cell_addr),
		.wdata(head.wdata),
		.re   (ram_re),
		.raddr(cell_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vbit_q      <= '0;
		end else begin
			if (load_rst || load_data || load_cmd)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (ram_we)
				vbit_q[cell_addr] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (ram_re)
						state_q <= S_READ;
				end
				S_READ: begin
					if (out_free)
						state_q <= wrap_q ? S_CMD : S_IDLE;
				end
				S_CMD: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// tick context and output payload
	always_ff @(posedge clk) begin
		if (ram_re) begin
			hit_q  <= in_range && vbit_q[cell_addr];
			wrap_q <= head.wrap;
			cmd_q  <= head.cmd;
		end
		if (load_rst) begin
			lcd_byte_q <= head.wdata;
			is_data_q  <= 1'b0;
			last_q     <= 1'b1;
		end else if (load_data) begin
			lcd_byte_q <= hit_q ? ram_rdata : 8'd0;
			is_data_q  <= 1'b1;
			last_q     <= !wrap_q;
		end else if (load_cmd) begin
			lcd_byte_q <= cmd_q;
			is_data_q  <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	`CLFR_ASSERT_NEXT(a_tick_reads, clk, arst_n, ram_re, state_q == S_READ, "tick did not start a read")
	`CLFR_ASSERT_NEXT(a_wrap_cmd, clk, arst_n, load_data && wrap_q, state_q == S_CMD && out_valid_q && is_data_q && !last_q, "row end lost its address command")
	`CLFR_ASSERT_NEXT(a_restart_out, clk, arst_n, load_rst, out_valid_q && !is_data_q && last_q, "restart command not presented")

endmodule

`default_nettype wire

[sv/char_lcd_frame_refresh.sv]
// Character LCD refresh scanner.
// Order: a restart request's command passes the queue register, then the output register;
//   a tick's character passes the queue register, the frame store read, then the output register.
// Sequence: the back end pops no new tick until its read state has passed, and an output stall
//   holds it; a row-end tick also passes the command state for its extra command. A write is done at its pop.
// Reset (arst_n low, asynchronous): frame store reads as zero, position 0/0,
//   registers 0/0 with row offsets 0, 64, 16, 80; queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// char_lcd_frame_refresh
// Frame store and scan position for a character LCD; emits data bytes and
// set-address commands in display order.
// ----------------------------------------------------------------------------
module char_lcd_frame_refresh #(
	parameter int FRAME_CELLS = clfr_pkg::FRAME_CELLS_DEF,
	parameter int QUEUE_DEPTH = clfr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [6:0] cell_index,
	input  wire logic [7:0] cell_char,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      lcd_byte,
	output logic            is_data,
	output logic            last,
	// register write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [6:0] cfg_data
);
	import clfr_pkg::*;

	cfg_t cfg_q;
	logic push;
	op_t  push_op;
	op_t  head;
	logic pop;
	logic q_full;
	logic q_empty;

	// Registers are always writable; the user keeps writes to idle periods.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count     <= 3'd0;
			cfg_q.column_count  <= 5'd0;
			cfg_q.row_offset[0] <= 7'd0;
			cfg_q.row_offset[1] <= 7'd64;
			cfg_q.row_offset[2] <= 7'd16;
			cfg_q.row_offset[3] <= 7'd80;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    cfg_q.row_count     <= cfg_data[2:0];
				REG_COLUMN_COUNT: cfg_q.column_count  <= cfg_data[4:0];
				REG_ROW_OFFSET_0: cfg_q.row_offset[0] <= cfg_data;
				REG_ROW_OFFSET_1: cfg_q.row_offset[1] <= cfg_data;
				REG_ROW_OFFSET_2: cfg_q.row_offset[2] <= cfg_data;
				REG_ROW_OFFSET_3: cfg_q.row_offset[3] <= cfg_data;
				default: ; // unmapped index, dropped
			endcase
		end
	end

	// Front: classifies each request against the geometry, moves the scan
	// position and queues the work. Requests that produce nothing (bad mode,
	// bad geometry, out-of-range write) are absorbed here.
	clfr_front #(
		.FRAME_CELLS(FRAME_CELLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.cell_index(cell_index),
		.cell_char (cell_char),
		.q_full    (q_full),
		.push      (push),
		.op        (push_op)
	);

	// Queue keeps writes and reads in request order, so a tick always sees
	// exactly the frame contents that preceded it.
	clfr_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: owns the frame store RAM and the output register.
	clfr_back #(
		.FRAME_CELLS(FRAME_CELLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lcd_byte (lcd_byte),
		.is_data  (is_data),
		.last     (last)
	);

endmodule

`default_nettype wire
